### rtl/cpxalu_pkg.sv
// Shared constants, codes and types of the complex accumulator ALU.
package cpxalu_pkg;

   localparam int DATA_WIDTH_DEF    = 32;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int FIELD_WIDTH       = 32;
   localparam int OP_WIDTH          = 3;
   localparam int STATUS_WIDTH      = 2;

   localparam logic [OP_WIDTH-1:0] OP_LOAD = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_ADD  = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_SUB  = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_MUL  = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_DIV  = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SAT     = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_DIVZERO = 2'd2;

   typedef struct packed {
      logic done;
      logic overflow;
   } div_status_type;

endpackage

### rtl/complex_accumulator_alu.sv
// Complex accumulator ALU: keeps a signed fixed-point complex accumulator (DATA_WIDTH bits,
// FRACTION_BITS fraction bits) and applies load, add, subtract, multiply or divide with each
// request transaction, answering with the new accumulator and a status (ok, saturated, divide
// by zero). One request is worked on at a time; req_ready is high only while idle, and a
// finished response may still be waiting on rsp_ready while the next request is taken. Load,
// add, subtract and unused codes are worked out in the decode state; multiply runs four products
// through the one shared DATA_WIDTH x DATA_WIDTH multiplier; divide runs six products for the
// denominator and numerators and two passes of the bit-serial divider, one quotient bit a cycle.
// Divide by zero is caught before any product.
module complex_accumulator_alu #(
   parameter int DATA_WIDTH    = cpxalu_pkg::DATA_WIDTH_DEF,
   parameter int FRACTION_BITS = cpxalu_pkg::FRACTION_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic        [cpxalu_pkg::OP_WIDTH-1:0]      req_operation,
   input  logic signed [cpxalu_pkg::FIELD_WIDTH-1:0]   req_operand_real,
   input  logic signed [cpxalu_pkg::FIELD_WIDTH-1:0]   req_operand_imag,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [cpxalu_pkg::FIELD_WIDTH-1:0]   rsp_result_real,
   output logic signed [cpxalu_pkg::FIELD_WIDTH-1:0]   rsp_result_imag,
   output logic        [cpxalu_pkg::STATUS_WIDTH-1:0]  rsp_status
);

   localparam int DW     = DATA_WIDTH;
   localparam int NW     = 2 * DATA_WIDTH;
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_LAST_MUL = 3'd3;
   localparam logic [STEP_W-1:0] STEP_LAST_DIV = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PROD,
      ST_ACCUM,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Saturate a wide signed sum to DW bits; the top bit of the result flags saturation.
   function automatic logic [DW:0] sat_wide(input logic signed [NW:0] v);
      logic same;
      same = (v[NW:DW-1] == {(NW-DW+2){v[NW]}});
      if (same)
         return {1'b0, v[DW-1:0]};
      else if (v[NW])
         return {1'b1, 1'b1, {(DW-1){1'b0}}};
      else
         return {1'b1, 1'b0, {(DW-1){1'b1}}};
   endfunction

   // Apply the sign to a quotient magnitude and saturate; top bit flags saturation.
   function automatic logic [DW:0] quo_sat(input logic [DW:0] q, input logic ovf,
                                           input logic neg);
      logic sat;
      if (neg) begin
         sat = ovf | q[DW] | (q[DW-1] & (|q[DW-2:0]));
         return sat ? {1'b1, 1'b1, {(DW-1){1'b0}}} : {1'b0, -q[DW-1:0]};
      end else begin
         sat = ovf | q[DW] | q[DW-1];
         return sat ? {1'b1, 1'b0, {(DW-1){1'b1}}} : {1'b0, q[DW-1:0]};
      end
   endfunction

   state_type                              state_ff, state_in;
   logic [cpxalu_pkg::OP_WIDTH-1:0]        op_ff, op_in;
   logic signed [DW-1:0]                   cr_ff, cr_in;
   logic signed [DW-1:0]                   ci_ff, ci_in;
   logic signed [DW-1:0]                   acc_real_ff, acc_real_in;
   logic signed [DW-1:0]                   acc_imag_ff, acc_imag_in;
   logic signed [DW-1:0]                   nr_ff, nr_in;
   logic signed [DW-1:0]                   ni_ff, ni_in;
   logic                                   sat_ff, sat_in;
   logic                                   dz_ff, dz_in;
   logic [STEP_W-1:0]                      step_ff, step_in;
   logic signed [NW-1:0]                   prod_ff, prod_in;
   logic signed [NW:0]                     sum_ff, sum_in;
   logic [NW-1:0]                          den_ff, den_in;
   logic signed [NW:0]                     numr_ff, numr_in;
   logic signed [NW:0]                     numi_ff, numi_in;
   logic                                   part_ff, part_in;
   logic                                   div_start_ff, div_start_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [cpxalu_pkg::STATUS_WIDTH-1:0]    status_ff, status_in;

   logic signed [DW-1:0]                   mul_a, mul_b;
   logic signed [NW-1:0]                   term;
   logic signed [NW:0]                     term_ext, total;
   logic                                   sub_term;
   logic [DW:0]                            sat_res, quo_res;
   logic [NW-1:0]                          div_num;
   logic                                   div_neg;
   logic [DW:0]                            div_quo;
   cpxalu_pkg::div_status_type             div_stat;

   // operand schedule of the shared multiplier
   always_comb begin
      mul_a = cr_ff;
      mul_b = cr_ff;
      if (op_ff == cpxalu_pkg::OP_MUL) begin
         unique case (step_ff)
            3'd0:    begin mul_a = acc_real_ff; mul_b = cr_ff; end
            3'd1:    begin mul_a = acc_imag_ff; mul_b = ci_ff; end
            3'd2:    begin mul_a = acc_real_ff; mul_b = ci_ff; end
            default: begin mul_a = acc_imag_ff; mul_b = cr_ff; end
         endcase
      end else begin
         unique case (step_ff)
            3'd0:    begin mul_a = cr_ff;       mul_b = cr_ff; end
            3'd1:    begin mul_a = ci_ff;       mul_b = ci_ff; end
            3'd2:    begin mul_a = acc_real_ff; mul_b = cr_ff; end
            3'd3:    begin mul_a = acc_imag_ff; mul_b = ci_ff; end
            3'd4:    begin mul_a = acc_imag_ff; mul_b = cr_ff; end
            default: begin mul_a = acc_real_ff; mul_b = ci_ff; end
         endcase
      end
   end

   assign prod_in  = NW'(mul_a) * NW'(mul_b);
   assign term     = (op_ff == cpxalu_pkg::OP_MUL) ? (prod_ff >>> FRACTION_BITS) : prod_ff;
   assign term_ext = (NW+1)'(term);
   assign sub_term = ((op_ff == cpxalu_pkg::OP_MUL) && (step_ff == 3'd1)) ||
                     ((op_ff == cpxalu_pkg::OP_DIV) && (step_ff == STEP_LAST_DIV));
   assign total    = !step_ff[0] ? term_ext :
                     (sub_term ? sum_ff - term_ext : sum_ff + term_ext);
   assign sat_res  = sat_wide(total);

   assign div_neg = part_ff ? numi_ff[NW] : numr_ff[NW];
   assign div_num = part_ff ? (numi_ff[NW] ? NW'(-numi_ff) : numi_ff[NW-1:0]) :
                              (numr_ff[NW] ? NW'(-numr_ff) : numr_ff[NW-1:0]);
   assign quo_res = quo_sat(div_quo, div_stat.overflow, div_neg);

   cpxalu_div #(
      .DATA_WIDTH    (DATA_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num),
      .den   (den_ff),
      .quo   (div_quo),
      .stat  (div_stat)
   );

   always_comb begin
      logic [DW:0] s_r, s_i;
      state_in     = state_ff;
      op_in        = op_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      acc_real_in  = acc_real_ff;
      acc_imag_in  = acc_imag_ff;
      nr_in        = nr_ff;
      ni_in        = ni_ff;
      sat_in       = sat_ff;
      dz_in        = dz_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      den_in       = den_ff;
      numr_in      = numr_ff;
      numi_in      = numi_ff;
      part_in      = part_ff;
      div_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      s_r          = '0;
      s_i          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               cr_in    = req_operand_real[DW-1:0];
               ci_in    = req_operand_imag[DW-1:0];
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            sat_in  = 1'b0;
            dz_in   = 1'b0;
            step_in = '0;
            nr_in   = acc_real_ff;
            ni_in   = acc_imag_ff;
            unique case (op_ff)
               cpxalu_pkg::OP_LOAD: begin
                  nr_in    = cr_ff;
                  ni_in    = ci_ff;
                  state_in = ST_FINISH;
               end
               cpxalu_pkg::OP_ADD: begin
                  s_r      = sat_wide((NW+1)'(acc_real_ff) + (NW+1)'(cr_ff));
                  s_i      = sat_wide((NW+1)'(acc_imag_ff) + (NW+1)'(ci_ff));
                  nr_in    = s_r[DW-1:0];
                  ni_in    = s_i[DW-1:0];
                  sat_in   = s_r[DW] | s_i[DW];
                  state_in = ST_FINISH;
               end
               cpxalu_pkg::OP_SUB: begin
                  s_r      = sat_wide((NW+1)'(acc_real_ff) - (NW+1)'(cr_ff));
                  s_i      = sat_wide((NW+1)'(acc_imag_ff) - (NW+1)'(ci_ff));
                  nr_in    = s_r[DW-1:0];
                  ni_in    = s_i[DW-1:0];
                  sat_in   = s_r[DW] | s_i[DW];
                  state_in = ST_FINISH;
               end
               cpxalu_pkg::OP_MUL: begin
                  state_in = ST_PROD;
               end
               cpxalu_pkg::OP_DIV: begin
                  if ((cr_ff == '0) && (ci_ff == '0)) begin
                     dz_in    = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_PROD;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_PROD: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            sum_in   = total;
            state_in = ST_PROD;
            step_in  = step_ff + STEP_W'(1);
            if (step_ff[0]) begin
               if (op_ff == cpxalu_pkg::OP_MUL) begin
                  sat_in = sat_ff | sat_res[DW];
                  if (step_ff == STEP_LAST_MUL) begin
                     ni_in    = sat_res[DW-1:0];
                     state_in = ST_FINISH;
                  end else begin
                     nr_in = sat_res[DW-1:0];
                  end
               end else begin
                  priority if (step_ff == 3'd1) begin
                     den_in = total[NW-1:0];
                  end else if (step_ff == 3'd3) begin
                     numr_in = total;
                  end else begin
                     numi_in      = total;
                     part_in      = 1'b0;
                     div_start_in = 1'b1;
                     state_in     = ST_DIVIDE;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               sat_in = sat_ff | quo_res[DW];
               if (!part_ff) begin
                  nr_in        = quo_res[DW-1:0];
                  part_in      = 1'b1;
                  div_start_in = 1'b1;
               end else begin
                  ni_in    = quo_res[DW-1:0];
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            // wait until the response register is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               acc_real_in  = nr_ff;
               acc_imag_in  = ni_ff;
               rsp_valid_in = 1'b1;
               priority if (dz_ff)
                  status_in = cpxalu_pkg::STATUS_DIVZERO;
               else if (sat_ff)
                  status_in = cpxalu_pkg::STATUS_SAT;
               else
                  status_in = cpxalu_pkg::STATUS_OK;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_real_ff  <= '0;
         acc_imag_ff  <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= cpxalu_pkg::STATUS_OK;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         acc_real_ff  <= acc_real_in;
         acc_imag_ff  <= acc_imag_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         step_ff      <= step_in;
      end
      op_ff   <= op_in;
      cr_ff   <= cr_in;
      ci_ff   <= ci_in;
      nr_ff   <= nr_in;
      ni_ff   <= ni_in;
      sat_ff  <= sat_in;
      dz_ff   <= dz_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      den_ff  <= den_in;
      numr_ff <= numr_in;
      numi_ff <= numi_in;
      part_ff <= part_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_real = cpxalu_pkg::FIELD_WIDTH'(acc_real_ff);
   assign rsp_result_imag = cpxalu_pkg::FIELD_WIDTH'(acc_imag_ff);
   assign rsp_status      = status_ff;

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished while sequencer not waiting on it");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PROD) || (state_ff == ST_ACCUM)) |-> (step_ff <= STEP_LAST_DIV))
      else $error("product step out of range");

   a_dz_no_change: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && dz_ff |-> (nr_ff == acc_real_ff) && (ni_ff == acc_imag_ff))
      else $error("divide by zero would change the accumulator");

endmodule

### rtl/cpxalu_div.sv
// Radix-2 restoring divider: floor(num * 2^FRACTION_BITS / den), one bit a cycle.
module cpxalu_div #(
   parameter int DATA_WIDTH    = cpxalu_pkg::DATA_WIDTH_DEF,
   parameter int FRACTION_BITS = cpxalu_pkg::FRACTION_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [2*DATA_WIDTH-1:0]      num,
   input  logic [2*DATA_WIDTH-1:0]      den,
   output logic [DATA_WIDTH:0]          quo,
   output cpxalu_pkg::div_status_type   stat
);

   localparam int NW = 2 * DATA_WIDTH;
   localparam int LW = NW + FRACTION_BITS;
   localparam int CW = $clog2(LW + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  ovf_ff, ovf_in;
   logic [LW-1:0]         dvd_ff, dvd_in;
   logic [NW-1:0]         rem_ff, rem_in;
   logic [NW-1:0]         den_ff, den_in;
   logic [DATA_WIDTH:0]   quo_ff, quo_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [NW:0]           shifted;
   logic [NW+1:0]         diff;
   logic                  fits;

   assign shifted = {rem_ff, dvd_ff[LW-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = !diff[NW+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         ovf_in  = 1'b0;
         dvd_in  = LW'(num) << FRACTION_BITS;
         rem_in  = '0;
         den_in  = den;
         quo_in  = '0;
         cnt_in  = CW'(LW);
      end else if (busy_ff) begin
         rem_in = fits ? diff[NW-1:0] : shifted[NW-1:0];
         dvd_in = dvd_ff << 1;
         // a one pushed out of the quotient register means the result is far out of range
         ovf_in = ovf_ff | quo_ff[DATA_WIDTH];
         quo_in = {quo_ff[DATA_WIDTH-1:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ovf_ff <= ovf_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign quo           = quo_ff;
   assign stat.done     = done_ff;
   assign stat.overflow = ovf_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < den_ff))
      else $error("partial remainder not below divisor");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");

endmodule

### dv/complex_accumulator_alu_tb.sv
// Self-checking testbench for the complex accumulator ALU: directed vectors, then random traffic.
`timescale 1ns / 1ps

module testbench;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [cpxalu_pkg::FIELD_WIDTH-1:0]  re;
      logic [cpxalu_pkg::FIELD_WIDTH-1:0]  im;
      logic [cpxalu_pkg::STATUS_WIDTH-1:0] status;
   } acc_result_type;

   typedef struct packed {
      logic [cpxalu_pkg::OP_WIDTH-1:0]     op;
      logic [cpxalu_pkg::FIELD_WIDTH-1:0]  re;
      logic [cpxalu_pkg::FIELD_WIDTH-1:0]  im;
      logic                                typed;
      logic [cpxalu_pkg::FIELD_WIDTH-1:0]  exp_re;
      logic [cpxalu_pkg::FIELD_WIDTH-1:0]  exp_im;
      logic [cpxalu_pkg::STATUS_WIDTH-1:0] exp_status;
   } vector_type;

   localparam int FB             = cpxalu_pkg::FRACTION_BITS_DEF;
   localparam int RANDOM_ITEMS   = 1880;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 250;
   localparam int HOLD_AFTER     = 300;
   localparam int HOLD_CYCLES    = 400;
   localparam int CALM_FIRST     = 700;
   localparam int CALM_LAST      = 1000;

   localparam logic [31:0] MAXV = 32'h7fff_ffff;
   localparam logic [31:0] MINV = 32'h8000_0000;
   localparam logic [31:0] NEG1 = 32'hffff_ffff;
   localparam logic [31:0] ONE  = 32'h0001_0000;
   localparam logic [31:0] ZERO = 32'h0000_0000;

   localparam wide_type FIELD_MAX = (wide_type'(1) <<< 31) - 1;
   localparam wide_type FIELD_MIN = -(wide_type'(1) <<< 31);

   localparam logic [cpxalu_pkg::OP_WIDTH-1:0] OP_LOAD   = cpxalu_pkg::OP_LOAD;
   localparam logic [cpxalu_pkg::OP_WIDTH-1:0] OP_ADD    = cpxalu_pkg::OP_ADD;
   localparam logic [cpxalu_pkg::OP_WIDTH-1:0] OP_SUB    = cpxalu_pkg::OP_SUB;
   localparam logic [cpxalu_pkg::OP_WIDTH-1:0] OP_MUL    = cpxalu_pkg::OP_MUL;
   localparam logic [cpxalu_pkg::OP_WIDTH-1:0] OP_DIV    = cpxalu_pkg::OP_DIV;
   localparam logic [cpxalu_pkg::OP_WIDTH-1:0] OP_SPARE5 = 3'd5;
   localparam logic [cpxalu_pkg::OP_WIDTH-1:0] OP_SPARE6 = 3'd6;
   localparam logic [cpxalu_pkg::OP_WIDTH-1:0] OP_SPARE7 = 3'd7;

   localparam logic [cpxalu_pkg::STATUS_WIDTH-1:0] ST_OK  = cpxalu_pkg::STATUS_OK;
   localparam logic [cpxalu_pkg::STATUS_WIDTH-1:0] ST_SAT = cpxalu_pkg::STATUS_SAT;
   localparam logic [cpxalu_pkg::STATUS_WIDTH-1:0] ST_DZ  = cpxalu_pkg::STATUS_DIVZERO;

   localparam int NUM_DIRECTED = 24;
   localparam vector_type DIRECTED [NUM_DIRECTED] = '{
      '{OP_ADD,    ZERO,  ZERO,  1'b1, ZERO, ZERO, ST_OK},      // accumulator after reset
      '{OP_LOAD,   MAXV,  MINV,  1'b1, MAXV, MINV, ST_OK},
      '{OP_ADD,    32'h1, NEG1,  1'b1, MAXV, MINV, ST_SAT},
      '{OP_DIV,    ZERO,  ZERO,  1'b1, MAXV, MINV, ST_DZ},
      '{OP_SUB,    NEG1,  32'h1, 1'b1, MAXV, MINV, ST_SAT},
      '{OP_LOAD,   ONE,   ZERO,  1'b1, ONE,  ZERO, ST_OK},
      '{OP_MUL,    ZERO,  ONE,   1'b1, ZERO, ONE,  ST_OK},
      '{OP_DIV,    ZERO,  ONE,   1'b1, ONE,  ZERO, ST_OK},
      '{OP_SUB,    ONE,   ZERO,  1'b1, ZERO, ZERO, ST_OK},
      '{OP_SPARE5, MAXV,  MINV,  1'b1, ZERO, ZERO, ST_OK},
      '{OP_SPARE6, NEG1,  ONE,   1'b1, ZERO, ZERO, ST_OK},
      '{OP_SPARE7, MINV,  MAXV,  1'b1, ZERO, ZERO, ST_OK},
      '{OP_LOAD,   MINV,  MINV,  1'b1, MINV, MINV, ST_OK},
      '{OP_MUL,    MINV,  MINV,  1'b0, ZERO, ZERO, ST_OK},
      '{OP_LOAD,   MAXV,  MAXV,  1'b1, MAXV, MAXV, ST_OK},
      '{OP_DIV,    32'h1, ZERO,  1'b0, ZERO, ZERO, ST_OK},
      '{OP_LOAD,   MINV,  MAXV,  1'b1, MINV, MAXV, ST_OK},
      '{OP_DIV,    32'h1, ZERO,  1'b0, ZERO, ZERO, ST_OK},
      '{OP_LOAD,   32'h1, NEG1,  1'b1, 32'h1, NEG1, ST_OK},
      '{OP_DIV,    MINV,  MINV,  1'b0, ZERO, ZERO, ST_OK},
      '{OP_LOAD,   NEG1,  ZERO,  1'b1, NEG1, ZERO, ST_OK},
      '{OP_MUL,    32'h1, ZERO,  1'b0, ZERO, ZERO, ST_OK},  // floor on negative product
      '{OP_DIV,    32'h0003_0000, ZERO, 1'b0, ZERO, ZERO, ST_OK},  // truncation to zero
      '{OP_DIV,    MAXV,  MINV,  1'b0, ZERO, ZERO, ST_OK}
   };

   logic                                       clock = 1'b0;
   logic                                       reset = 1'b1;
   logic                                       req_valid = 1'b0;
   logic                                       req_ready;
   logic [cpxalu_pkg::OP_WIDTH-1:0]            req_operation = cpxalu_pkg::OP_LOAD;
   logic signed [cpxalu_pkg::FIELD_WIDTH-1:0]  req_operand_real = '0;
   logic signed [cpxalu_pkg::FIELD_WIDTH-1:0]  req_operand_imag = '0;
   logic                                       rsp_valid;
   logic                                       rsp_ready = 1'b0;
   logic signed [cpxalu_pkg::FIELD_WIDTH-1:0]  rsp_result_real;
   logic signed [cpxalu_pkg::FIELD_WIDTH-1:0]  rsp_result_imag;
   logic [cpxalu_pkg::STATUS_WIDTH-1:0]        rsp_status;

   logic signed [31:0] acc_re = '0;
   logic signed [31:0] acc_im = '0;
   acc_result_type     awaited_accumulators [$];
   bit                 calm_window = 1'b0;
   int                 fail_count = 0;
   int                 op_count [8] = '{default: 0};
   int                 sat_seen = 0;
   int                 divzero_seen = 0;

   complex_accumulator_alu dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_operand_real (req_operand_real),
      .req_operand_imag (req_operand_imag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_real  (rsp_result_real),
      .rsp_result_imag  (rsp_result_imag),
      .rsp_status       (rsp_status)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] clamp(input wide_type v);
      logic [31:0] r;
      if (v > FIELD_MAX) r = MAXV;
      else if (v < FIELD_MIN) r = MINV;
      else r = v[31:0];
      return r;
   endfunction

   // Advances the shadow accumulator by one operation and returns the response it should give.
   function automatic acc_result_type apply_operation(
      input logic [cpxalu_pkg::OP_WIDTH-1:0] op,
      input logic [31:0] cre, input logic [31:0] cim);
      wide_type       ar, ai, cr, ci, nr, ni, den;
      acc_result_type res;
      ar = wide_type'(acc_re);
      ai = wide_type'(acc_im);
      cr = wide_type'($signed(cre));
      ci = wide_type'($signed(cim));
      nr = ar;
      ni = ai;
      res.status = ST_OK;
      case (op)
         OP_LOAD: begin
            nr = cr;
            ni = ci;
         end
         OP_ADD: begin
            nr = ar + cr;
            ni = ai + ci;
         end
         OP_SUB: begin
            nr = ar - cr;
            ni = ai - ci;
         end
         OP_MUL: begin
            nr = ((ar * cr) >>> FB) - ((ai * ci) >>> FB);
            ni = ((ar * ci) >>> FB) + ((ai * cr) >>> FB);
         end
         OP_DIV: begin
            den = cr * cr + ci * ci;
            if (den == 0) begin
               res.status = ST_DZ;
            end else begin
               // signed divide truncates toward zero; the numerator is exact at this width
               nr = ((ar * cr + ai * ci) <<< FB) / den;
               ni = ((ai * cr - ar * ci) <<< FB) / den;
            end
         end
         default: ;
      endcase
      if (nr > FIELD_MAX || nr < FIELD_MIN || ni > FIELD_MAX || ni < FIELD_MIN)
         res.status = ST_SAT;
      res.re = clamp(nr);
      res.im = clamp(ni);
      acc_re = res.re;
      acc_im = res.im;
      return res;
   endfunction

   function automatic logic [31:0] pick_operand();
      logic [31:0] v;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(5))
               0: v = MAXV;
               1: v = MINV;
               2: v = ZERO;
               3: v = 32'h1;
               4: v = NEG1;
               default: v = ONE;
            endcase
         end
         1, 2, 3: v = $urandom();
         default: v = $urandom_range(32'h0020_0000) - 32'h0010_0000;  // within +-16.0
      endcase
      return v;
   endfunction

   // Holds the transaction until accepted, then records the response it should produce.
   task automatic issue_request(input logic [cpxalu_pkg::OP_WIDTH-1:0] op,
                                input logic [31:0] re, input logic [31:0] im,
                                input acc_result_type want);
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_operand_real <= re;
      req_operand_imag <= im;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_accumulators.push_back(want);
      op_count[op]++;
      if (!calm_window) begin
         while ($urandom_range(99) < 29) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   initial begin : stimulus
      acc_result_type                  want;
      logic [cpxalu_pkg::OP_WIDTH-1:0] op;
      logic [31:0]                     re, im;
      int                              r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         want = apply_operation(DIRECTED[i].op, DIRECTED[i].re, DIRECTED[i].im);
         if (DIRECTED[i].typed)
            want = '{DIRECTED[i].exp_re, DIRECTED[i].exp_im, DIRECTED[i].exp_status};
         issue_request(DIRECTED[i].op, DIRECTED[i].re, DIRECTED[i].im, want);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm_window = (i >= CALM_FIRST && i < CALM_LAST);
         r = $urandom_range(99);
         if (r < 14) op = OP_LOAD;
         else if (r < 28) op = OP_ADD;
         else if (r < 42) op = OP_SUB;
         else if (r < 66) op = OP_MUL;
         else if (r < 94) op = OP_DIV;
         else op = cpxalu_pkg::OP_WIDTH'($urandom_range(OP_SPARE7, OP_SPARE5));
         re = pick_operand();
         im = pick_operand();
         if (op == OP_DIV && $urandom_range(99) < 6) begin
            re = ZERO;
            im = ZERO;
         end
         want = apply_operation(op, re, im);
         issue_request(op, re, im, want);
      end
      calm_window = 1'b0;
      req_valid <= 1'b0;
      while (awaited_accumulators.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d transactions: load %0d, add %0d, sub %0d, mul %0d, div %0d, spare %0d",
               NUM_DIRECTED + RANDOM_ITEMS, op_count[OP_LOAD], op_count[OP_ADD],
               op_count[OP_SUB], op_count[OP_MUL], op_count[OP_DIV],
               op_count[OP_SPARE5] + op_count[OP_SPARE6] + op_count[OP_SPARE7]);
      $display("responses with saturation %0d, with divide by zero %0d, mismatches %0d",
               sat_seen, divzero_seen, fail_count);
      if (fail_count == 0) begin
         $display("complex_accumulator_alu regression: pass");
      end else begin
         $display("complex_accumulator_alu regression: fail");
      end
      $finish;
   end

   initial begin : response_side
      acc_result_type got, want;
      int             seen;
      int             stall_left;
      bit             stalled_once;
      seen         = 0;
      stall_left   = 0;
      stalled_once = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = '{rsp_result_real, rsp_result_imag, rsp_status};
            seen++;
            if (awaited_accumulators.size() == 0) begin
               $error("response transaction with nothing outstanding: %h %h %h",
                      got.re, got.im, got.status);
               fail_count++;
            end else begin
               want = awaited_accumulators.pop_front();
               if (got.re !== want.re) begin
                  $error("result_real: expected %h, got %h", want.re, got.re);
                  fail_count++;
               end
               if (got.im !== want.im) begin
                  $error("result_imag: expected %h, got %h", want.im, got.im);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
            end
            if (got.status == ST_SAT) sat_seen++;
            if (got.status == ST_DZ) divzero_seen++;
         end
         // one long back-pressure spell so the block fills and stalls its request side
         if (!stalled_once && seen == HOLD_AFTER) begin
            stalled_once = 1'b1;
            stall_left   = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm_window || ($urandom_range(99) >= 29);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("complex_accumulator_alu regression: fail");
      $finish;
   end

endmodule
